[hw/rtl/sdc_pkg.sv]
// ----------------------------------------------------------------------------
// sdc_pkg: shared types and constants for the sifting SD criterion
// Controller state, command/status structs and fixed-point constants.
// ----------------------------------------------------------------------------
package sdc_pkg;

  localparam int SD_BITS   = 32;   // UQ16.16 sum
  localparam int TERM_BITS = 24;   // UQ8.16 term
  localparam int TERM_FRAC = 16;   // fraction bits of a term
  localparam int DIV_STEPS = 24;   // one quotient bit per step
  localparam int CNT_BITS  = 5;    // holds DIV_STEPS-1
  localparam int SAT_SHIFT = 4;    // term saturates when |d| >= 16*|p|

  localparam logic [SD_BITS-1:0]   FIXED_THREE = 32'd196608;
  localparam logic [TERM_BITS-1:0] TERM_MAX    = 24'hFF_FFFF;
  localparam logic [SD_BITS-1:0]   SUM_MAX     = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SQUARE,
    ST_DIV,
    ST_ACC,
    ST_STORE,
    ST_EMIT
  } sdc_state_e;

  // controller -> datapath
  typedef struct packed {
    logic accept;    // capture word, issue store read
    logic ld_ab;     // register |d|, |p| and the special-case flags
    logic ld_sq;     // register squares, arm divider
    logic div_step;  // one restoring-division step
    logic acc;       // add term into the sum
    logic store;     // write sample back, advance index
    logic emit;      // load result register, clear for next vector
  } sdc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic have_prev;
    logic in_range;
    logic last;
    logic out_free;
  } sdc_sts_t;

endpackage

[hw/rtl/sdc_ram.sv]
// ----------------------------------------------------------------------------
// sdc_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sdc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/sdc_ctrl.sv]
// ----------------------------------------------------------------------------
// sdc_ctrl: sequencing FSM for the SD criterion
// Steps compared words through read, square, divide, accumulate and store.
// ----------------------------------------------------------------------------
module sdc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sdc_pkg::sdc_sts_t sts_i,
  output sdc_pkg::sdc_cmd_t cmd_o
);

  sdc_pkg::sdc_state_e state_q, state_d;
  logic [sdc_pkg::CNT_BITS-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sdc_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      sdc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          // compare only when a previous vector exists at this index
          if (sts_i.have_prev && sts_i.in_range) begin
            state_d = sdc_pkg::ST_READ;
          end else begin
            state_d = sdc_pkg::ST_STORE;
          end
        end
      end
      sdc_pkg::ST_READ: begin
        cmd_o.ld_ab = 1'b1;
        state_d     = sdc_pkg::ST_SQUARE;
      end
      sdc_pkg::ST_SQUARE: begin
        cmd_o.ld_sq = 1'b1;
        cnt_d       = '0;
        state_d     = sdc_pkg::ST_DIV;
      end
      sdc_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == sdc_pkg::CNT_BITS'(sdc_pkg::DIV_STEPS - 1)) begin
          state_d = sdc_pkg::ST_ACC;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      sdc_pkg::ST_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = sdc_pkg::ST_STORE;
      end
      sdc_pkg::ST_STORE: begin
        cmd_o.store = 1'b1;
        state_d     = sts_i.last ? sdc_pkg::ST_EMIT : sdc_pkg::ST_IDLE;
      end
      sdc_pkg::ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = sdc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = sdc_pkg::ST_IDLE;
      end
    endcase
  end

  a_div_ends_in_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sdc_pkg::ST_DIV &&
     cnt_q == sdc_pkg::CNT_BITS'(sdc_pkg::DIV_STEPS - 1)) |=> state_q == sdc_pkg::ST_ACC)
    else $error("divider did not hand over to accumulate");

  a_one_stage_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o))
    else $error("more than one datapath command at once");

endmodule

[hw/rtl/sdc_datapath.sv]
// ----------------------------------------------------------------------------
// sdc_datapath: store, squarer, serial divider and sum for the SD criterion
// Holds the previous vector, index, running sum and the result register.
// ----------------------------------------------------------------------------
module sdc_datapath #(
  parameter int MAX_LEN     = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  sdc_pkg::sdc_cmd_t          cmd_i,
  output sdc_pkg::sdc_sts_t          sts_o,
  input  logic [SAMPLE_BITS-1:0]     sample_i,
  input  logic                       last_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [sdc_pkg::SD_BITS-1:0] sd_value_o,
  output logic                       no_previous_o,
  output logic                       saturated_o
);

  localparam int SB = SAMPLE_BITS;
  localparam int IW = $clog2(MAX_LEN + 1);
  localparam int AW = $clog2(MAX_LEN);
  localparam int W  = 2 * SB + 24;   // divider remainder/divisor width
  localparam int TB = sdc_pkg::TERM_BITS;

  // input capture
  logic [SB-1:0] sample_q;
  logic          last_q;

  // vector state
  logic [IW-1:0] idx_q, idx_d;
  logic          have_prev_q, have_prev_d;
  logic [sdc_pkg::SD_BITS-1:0] acc_q, acc_d;
  logic          sat_seen_q, sat_seen_d;
  logic          in_range;

  // term pipeline
  logic [SB-1:0] prev;
  logic [SB:0]   diff, a_mag, b_full;
  logic [SB:0]   a_q;
  logic [SB-1:0] b_q;
  logic          zero_q, tsat_q;
  logic [W-1:0]  rem_q, rem_d, dv_q, dv_d;
  logic [TB-1:0] q_q, q_d;
  logic [2*SB+1:0] a_sq;
  logic [2*SB-1:0] b_sq;
  logic          ge;
  logic [TB-1:0] term;
  logic [sdc_pkg::SD_BITS:0] sum;

  // result register
  logic                        out_valid_q, out_valid_d;
  logic [sdc_pkg::SD_BITS-1:0] sd_q;
  logic                        nprev_q, osat_q;

  assign in_range = idx_q < IW'(MAX_LEN);

  sdc_ram #(
    .WIDTH(SB),
    .DEPTH(MAX_LEN)
  ) u_prev_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.store & in_range),
    .waddr_i(idx_q[AW-1:0]),
    .wdata_i(sample_q),
    .re_i   (cmd_i.accept),
    .raddr_i(idx_q[AW-1:0]),
    .rdata_o(prev)
  );

  // d = prev - cur, magnitudes of d and prev
  assign diff   = {prev[SB-1], prev} - {sample_q[SB-1], sample_q};
  assign a_mag  = diff[SB] ? (~diff + 1'b1) : diff;
  assign b_full = prev[SB-1] ? (~{prev[SB-1], prev} + 1'b1) : {1'b0, prev};

  assign a_sq = a_q * a_q;
  assign b_sq = b_q * b_q;

  // restoring division step
  assign ge    = rem_q >= dv_q;
  assign rem_d = ge ? (rem_q - dv_q) : rem_q;
  assign dv_d  = dv_q >> 1;
  assign q_d   = {q_q[TB-2:0], ge};

  assign term = zero_q ? '0 : (tsat_q ? sdc_pkg::TERM_MAX : q_q);
  assign sum  = {1'b0, acc_q} + (sdc_pkg::SD_BITS + 1)'(term);

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      sample_q <= sample_i;
      last_q   <= last_i;
    end
    if (cmd_i.ld_ab) begin
      a_q    <= a_mag;
      b_q    <= b_full[SB-1:0];
      zero_q <= (prev == '0);
      tsat_q <= (SB + 5)'(a_mag) >= ((SB + 5)'(b_full) << sdc_pkg::SAT_SHIFT);
    end
    if (cmd_i.ld_sq) begin
      rem_q <= W'(a_sq) << sdc_pkg::TERM_FRAC;
      dv_q  <= W'(b_sq) << (sdc_pkg::DIV_STEPS - 1);
      q_q   <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_d;
      dv_q  <= dv_d;
      q_q   <= q_d;
    end
    if (cmd_i.emit) begin
      sd_q    <= have_prev_q ? acc_q : sdc_pkg::FIXED_THREE;
      nprev_q <= ~have_prev_q;
      osat_q  <= have_prev_q & sat_seen_q;
    end
  end

  always_comb begin
    idx_d       = idx_q;
    have_prev_d = have_prev_q;
    acc_d       = acc_q;
    sat_seen_d  = sat_seen_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.acc) begin
      acc_d      = sum[sdc_pkg::SD_BITS] ? sdc_pkg::SUM_MAX : sum[sdc_pkg::SD_BITS-1:0];
      sat_seen_d = sat_seen_q | (tsat_q & ~zero_q) | sum[sdc_pkg::SD_BITS];
    end
    if (cmd_i.store && in_range) begin
      idx_d = idx_q + 1'b1;
    end
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      have_prev_d = 1'b1;
      idx_d       = '0;
      acc_d       = '0;
      sat_seen_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      have_prev_q <= 1'b0;
      acc_q       <= '0;
      sat_seen_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      have_prev_q <= have_prev_d;
      acc_q       <= acc_d;
      sat_seen_q  <= sat_seen_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign sts_o.have_prev = have_prev_q;
  assign sts_o.in_range  = in_range;
  assign sts_o.last      = last_q;
  assign sts_o.out_free  = ~out_valid_q | out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign sd_value_o    = sd_q;
  assign no_previous_o = nprev_q;
  assign saturated_o   = osat_q;

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= IW'(MAX_LEN))
    else $error("sample index ran past the store depth");

  a_emit_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> out_valid_q && have_prev_q && idx_q == '0)
    else $error("result load did not take effect");

  a_first_no_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && nprev_q) |-> (!osat_q && sd_q == sdc_pkg::FIXED_THREE))
    else $error("first-vector result is not the fixed value");

endmodule

[hw/rtl/sifting_sd_criterion.sv]
// ----------------------------------------------------------------------------
// sifting_sd_criterion: EMD sifting stop test, standard-deviation criterion
// Sifting candidate vectors stream in one sample per word on the slave side,
// tlast on the final sample. Each sample is compared with the sample at the
// same index of the previous vector (kept in an on-chip RAM of MAX_LEN
// entries) and then replaces it; the term floor(2^16*(prev-new)^2/prev^2),
// UQ8.16, saturating at 0xFFFFFF when |prev-new| >= 16*|prev|, zero where
// prev is zero, is added into a saturating UQ16.16 sum. On tlast one word
// goes out on the master side: the sum, or the fixed 3.0 (196608) with
// no_previous set for the first vector after reset. Samples past MAX_LEN-1
// are neither compared nor stored. A compared sample goes through accept,
// RAM read, squaring, 24 steps of the bit-serial restoring divider,
// accumulate and write back; a first-vector sample only through accept and
// write back. A last sample then loads the output register once any earlier
// result is taken; it then waits for tready as the next vector is taken in. The
// RAM is not cleared: every index a vector reaches must have been written by an
// earlier vector since reset, which holds when vectors have equal length.
// ----------------------------------------------------------------------------
module sifting_sd_criterion #(
  parameter int MAX_LEN     = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // slave side: tdata = sample [SAMPLE_BITS-1:0], zero padded to bytes
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [((SAMPLE_BITS + 7) / 8)*8-1:0] s_axis_tdata,
  input  logic                               s_axis_tlast,
  // master side: tdata = sd_value [31:0]
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [sdc_pkg::SD_BITS-1:0]        m_axis_tdata,
  // tuser = no_previous [0], saturated [1]
  output logic [1:0]                         m_axis_tuser
);

  sdc_pkg::sdc_cmd_t cmd;
  sdc_pkg::sdc_sts_t sts;

  logic no_previous;
  logic saturated;

  // sequencer: one word in flight at a time
  sdc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // previous-vector RAM, term arithmetic, running sum, output register
  sdc_datapath #(
    .MAX_LEN    (MAX_LEN),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .sample_i     (s_axis_tdata[SAMPLE_BITS-1:0]),
    .last_i       (s_axis_tlast),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .sd_value_o   (m_axis_tdata),
    .no_previous_o(no_previous),
    .saturated_o  (saturated)
  );

  assign m_axis_tuser = {saturated, no_previous};

endmodule
